[rtl/rgbhsl_pkg.sv]
`timescale 1ns / 1ps
package rgbhsl_pkg;

  localparam int ChanW    = 8;
  localparam int SumW     = ChanW + 1;
  localparam int DivW     = 10;
  localparam int RemW     = 11;
  localparam int QuoW     = 18;
  localparam int DivSteps = 3;
  localparam int DivStgs  = QuoW / DivSteps;

  localparam logic [DivW-1:0] FracTwo  = 10'd512;
  localparam logic [SumW-1:0] FracHalf = 9'd256;
  localparam logic [9:0]      Deg360   = 10'd360;
  localparam logic [9:0]      Deg300   = 10'd300;
  localparam logic [9:0]      Deg180   = 10'd180;
  localparam logic [9:0]      Deg60    = 10'd60;
  localparam logic [6:0]      Pct100   = 7'd100;
  localparam logic [5:0]      Mul60    = 6'd60;

  // hue sector: base angle and sign of the ratio term
  typedef enum logic [2:0] {
    H_300P,
    H_60M,
    H_60P,
    H_180M,
    H_180P,
    H_300M
  } hsel_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] q;
  } dstate_t;

  typedef struct packed {
    dstate_t         sat;
    dstate_t         hue;
    logic [DivW-1:0] sat_d;
    logic [DivW-1:0] hue_d;
    hsel_t           sel;
    logic            gray;
    logic [6:0]      light;
  } stg_t;

  // one restoring step: compare, subtract, shift
  function automatic dstate_t div_step(dstate_t s, logic [DivW-1:0] d);
    dstate_t         o;
    logic            bit_q;
    logic [RemW-1:0] diff;
    bit_q = (s.rem >= {1'b0, d});
    diff  = bit_q ? (s.rem - {1'b0, d}) : s.rem;
    o.rem = {diff[RemW-2:0], 1'b0};
    o.q   = {s.q[QuoW-2:0], bit_q};
    return o;
  endfunction

endpackage

[rtl/rgbhsl_in_if.sv]
`timescale 1ns / 1ps
interface rgbhsl_in_if;
  logic                            valid;
  logic                            ready;
  logic [rgbhsl_pkg::ChanW-1:0]    red_in;
  logic [rgbhsl_pkg::ChanW-1:0]    green_in;
  logic [rgbhsl_pkg::ChanW-1:0]    blue_in;

  modport source(output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

[rtl/rgbhsl_out_if.sv]
`timescale 1ns / 1ps
interface rgbhsl_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue_out;
  logic [6:0] sat_out;
  logic [6:0] light_out;

  modport source(output valid, output hue_out, output sat_out, output light_out, input ready);
  modport sink(input valid, input hue_out, input sat_out, input light_out, output ready);
endinterface

[rtl/rgbhsl_front.sv]
`timescale 1ns / 1ps
module rgbhsl_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         valid_in,
  input  logic [rgbhsl_pkg::ChanW-1:0] red,
  input  logic [rgbhsl_pkg::ChanW-1:0] green,
  input  logic [rgbhsl_pkg::ChanW-1:0] blue,
  input  logic                         en_next,
  output logic                         en,
  output logic                         valid_r,
  output rgbhsl_pkg::stg_t             data_r
);
  logic [rgbhsl_pkg::ChanW-1:0] hi, lo, num;
  logic [rgbhsl_pkg::SumW-1:0]  sum;
  logic [15:0]                  lmul;
  rgbhsl_pkg::stg_t             data_nxt;

  assign en = !valid_r || en_next;

  always_comb begin
    hi = (red > green) ? red : green;
    hi = (hi > blue) ? hi : blue;
    lo = (red < green) ? red : green;
    lo = (lo < blue) ? lo : blue;
    sum = {1'b0, hi} + {1'b0, lo};
    lmul = {7'd0, sum} * {9'd0, rgbhsl_pkg::Pct100};

    if (red == hi) begin
      data_nxt.sel = (green == lo) ? rgbhsl_pkg::H_300P : rgbhsl_pkg::H_60M;
      num = (green == lo) ? (hi - blue) : (hi - green);
    end else if (green == hi) begin
      data_nxt.sel = (blue == lo) ? rgbhsl_pkg::H_60P : rgbhsl_pkg::H_180M;
      num = (blue == lo) ? (hi - red) : (hi - blue);
    end else begin
      data_nxt.sel = (red == lo) ? rgbhsl_pkg::H_180P : rgbhsl_pkg::H_300M;
      num = (red == lo) ? (hi - green) : (hi - red);
    end

    data_nxt.gray  = (sum == '0) || (hi == lo);
    data_nxt.light = lmul[15:9];
    data_nxt.sat_d = (sum < rgbhsl_pkg::FracHalf) ? {1'b0, sum}
                                                  : (rgbhsl_pkg::FracTwo - {1'b0, sum});
    data_nxt.hue_d = {2'd0, hi - lo};
    data_nxt.sat.rem = {3'd0, hi - lo};
    data_nxt.sat.q   = '0;
    data_nxt.hue.rem = {3'd0, num};
    data_nxt.hue.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end
endmodule

[rtl/rgbhsl_div_stage.sv]
`timescale 1ns / 1ps
module rgbhsl_div_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_in,
  input  rgbhsl_pkg::stg_t data_in,
  input  logic             en_next,
  output logic             en,
  output logic             valid_r,
  output rgbhsl_pkg::stg_t data_r
);
  rgbhsl_pkg::stg_t data_nxt;

  assign en = !valid_r || en_next;

  always_comb begin
    data_nxt = data_in;
    for (int k = 0; k < rgbhsl_pkg::DivSteps; k++) begin
      data_nxt.sat = rgbhsl_pkg::div_step(data_nxt.sat, data_in.sat_d);
      data_nxt.hue = rgbhsl_pkg::div_step(data_nxt.hue, data_in.hue_d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end
endmodule

[rtl/rgbhsl_back.sv]
`timescale 1ns / 1ps
module rgbhsl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_in,
  input  rgbhsl_pkg::stg_t data_in,
  input  logic             out_ready,
  output logic             en,
  output logic             valid_r,
  output logic [8:0]       hue_r,
  output logic [6:0]       sat_r,
  output logic [6:0]       light_r
);
  logic [16:0] qs, qh;
  logic [23:0] smul;
  logic [22:0] hmul;
  logic [9:0]  ratio, deg;
  logic [8:0]  hue_nxt;
  logic [6:0]  sat_nxt;

  assign en = !valid_r || out_ready;

  always_comb begin
    // extra quotient bit at the bottom: drop it
    qs = data_in.sat.q[rgbhsl_pkg::QuoW-1:1];
    qh = data_in.hue.q[rgbhsl_pkg::QuoW-1:1];
    smul = qs * rgbhsl_pkg::Pct100;
    hmul = qh * rgbhsl_pkg::Mul60;
    ratio = {3'd0, hmul[22:16]};
    case (data_in.sel)
      rgbhsl_pkg::H_300P: deg = rgbhsl_pkg::Deg300 + ratio;
      rgbhsl_pkg::H_60M:  deg = rgbhsl_pkg::Deg60 - ratio;
      rgbhsl_pkg::H_60P:  deg = rgbhsl_pkg::Deg60 + ratio;
      rgbhsl_pkg::H_180M: deg = rgbhsl_pkg::Deg180 - ratio;
      rgbhsl_pkg::H_180P: deg = rgbhsl_pkg::Deg180 + ratio;
      rgbhsl_pkg::H_300M: deg = rgbhsl_pkg::Deg300 - ratio;
      default:            deg = '0;
    endcase
    if (deg >= rgbhsl_pkg::Deg360) begin
      deg = deg - rgbhsl_pkg::Deg360;
    end
    hue_nxt = data_in.gray ? 9'd0 : deg[8:0];
    sat_nxt = data_in.gray ? 7'd0 : smul[22:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      light_r <= data_in.light;
    end
  end
endmodule

[rtl/rgb_to_hsl_fixed.sv]
`timescale 1ns / 1ps
// Pipeline: front stage, six divider stages of three quotient bits each, then
// output stage.
// Throughput: one pixel per cycle; each stage holds only when the next is full.
// Reset: synchronous, active low; clears all valid bits, data is not reset.
module rgb_to_hsl_fixed (
  input  logic         clk,
  input  logic         rst_n,
  rgbhsl_in_if.sink    in_ch,
  rgbhsl_out_if.source out_ch
);
  logic             v   [0:rgbhsl_pkg::DivStgs];
  rgbhsl_pkg::stg_t d   [0:rgbhsl_pkg::DivStgs];
  logic             en  [0:rgbhsl_pkg::DivStgs+1];

  rgbhsl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (in_ch.valid),
    .red      (in_ch.red_in),
    .green    (in_ch.green_in),
    .blue     (in_ch.blue_in),
    .en_next  (en[1]),
    .en       (en[0]),
    .valid_r  (v[0]),
    .data_r   (d[0])
  );

  for (genvar i = 0; i < rgbhsl_pkg::DivStgs; i++) begin : g_div
    rgbhsl_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .valid_in (v[i]),
      .data_in  (d[i]),
      .en_next  (en[i+2]),
      .en       (en[i+1]),
      .valid_r  (v[i+1]),
      .data_r   (d[i+1])
    );
  end

  rgbhsl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v[rgbhsl_pkg::DivStgs]),
    .data_in   (d[rgbhsl_pkg::DivStgs]),
    .out_ready (out_ch.ready),
    .en        (en[rgbhsl_pkg::DivStgs+1]),
    .valid_r   (out_ch.valid),
    .hue_r     (out_ch.hue_out),
    .sat_r     (out_ch.sat_out),
    .light_r   (out_ch.light_out)
  );

  assign in_ch.ready = en[0];

`ifndef SYNTH
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.hue_out < 9'd360)
    else $error("hue out of range");
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.sat_out <= 7'd100)
    else $error("saturation out of range");
  a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.light_out <= 7'd99)
    else $error("lightness out of range");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");
`endif
endmodule

[sim/rgb_to_hsl_fixed_tb.sv]
`timescale 1ns / 1ps
module rgb_to_hsl_fixed_tb;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] light;
  } hsl_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  hsl_t hsl_pending[$];

  rgbhsl_in_if  in_ch();
  rgbhsl_out_if out_ch();

  rgb_to_hsl_fixed DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.red_in   = '0;
    in_ch.green_in = '0;
    in_ch.blue_in  = '0;
    out_ch.ready   = 1'b0;
  end

  function automatic logic [31:0] sector_deg(logic [31:0] top, logic [31:0] chan,
                                             logic [31:0] spread);
    logic [31:0] ratio;
    ratio = ((top - chan) << 16) / spread;
    return (ratio * 60) >> 16;
  endfunction

  function automatic hsl_t convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    logic [31:0] r, g, b, hi, lo, lf, sf, hdeg, spread, dv, rr, gg, bb;
    hsl_t res;
    r = {16'd0, r8, 8'd0};
    g = {16'd0, g8, 8'd0};
    b = {16'd0, b8, 8'd0};
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    lf = (hi + lo) >> 1;
    sf = 0;
    hdeg = 0;
    if (lf != 0 && hi != lo) begin
      spread = hi - lo;
      dv = (lf < 32768) ? (hi + lo) : (131072 - hi - lo);
      sf = (spread << 16) / dv;
      rr = sector_deg(hi, r, spread);
      gg = sector_deg(hi, g, spread);
      bb = sector_deg(hi, b, spread);
      if (r == hi) hdeg = (g == lo) ? 300 + bb : 60 - gg;
      else if (g == hi) hdeg = (b == lo) ? 60 + rr : 180 - bb;
      else hdeg = (r == lo) ? 180 + gg : 300 - rr;
    end
    res.hue   = 9'(hdeg % 360);
    res.sat   = 7'((sf * 100) >> 16);
    res.light = 7'((lf * 100) >> 16);
    return res;
  endfunction

  // hold valid low through idle cycles, then offer the word until accepted
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.red_in   <= r;
    in_ch.green_in <= g;
    in_ch.blue_in  <= b;
    hsl_pending.push_back(convert_pixel(r, g, b));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // drive ready at each edge; check words accepted at the edge
  always @(posedge clk) begin
    hsl_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (hsl_pending.size() == 0) begin
          $error("unexpected word hue=%0d", out_ch.hue_out);
          errors++;
        end else begin
          want = hsl_pending.pop_front();
          if (out_ch.hue_out !== want.hue) begin
            $error("hue_out expected %0d actual %0d", want.hue, out_ch.hue_out);
            errors++;
          end
          if (out_ch.sat_out !== want.sat) begin
            $error("sat_out expected %0d actual %0d", want.sat, out_ch.sat_out);
            errors++;
          end
          if (out_ch.light_out !== want.light) begin
            $error("light_out expected %0d actual %0d", want.light, out_ch.light_out);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic test_extremes();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
  endtask

  task automatic test_sectors();
    send_pixel(8'd200, 8'd10, 8'd90);
    send_pixel(8'd200, 8'd90, 8'd10);
    send_pixel(8'd90, 8'd200, 8'd10);
    send_pixel(8'd10, 8'd200, 8'd90);
    send_pixel(8'd10, 8'd90, 8'd200);
    send_pixel(8'd90, 8'd10, 8'd200);
  endtask

  task automatic test_ties();
    send_pixel(8'd200, 8'd200, 8'd50);
    send_pixel(8'd50, 8'd200, 8'd200);
    send_pixel(8'd200, 8'd50, 8'd200);
    send_pixel(8'd127, 8'd128, 8'd127);
    send_pixel(8'd128, 8'd127, 8'd128);
    send_pixel(8'd170, 8'd85, 8'd85);
  endtask

  task automatic test_random(int count);
    logic [7:0] c [3];
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 3; k++) c[k] = 8'($urandom);
      // force ties or grays now and then
      case ($urandom_range(5))
        0: c[1] = c[0];
        1: c[2] = c[1];
        2: begin c[1] = c[0]; c[2] = c[0]; end
        default: ;
      endcase
      send_pixel(c[0], c[1], c[2]);
    end
  endtask

  initial begin
    int guard;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_idle_pct = 27;
    snk_idle_pct = 60;
    test_extremes();
    test_sectors();
    test_ties();
    test_random(170);
    src_idle_pct = 60;
    snk_idle_pct = 27;
    test_random(170);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(160);
    in_ch.valid <= 1'b0;
    guard = 0;
    while (hsl_pending.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && hsl_pending.size() == 0) begin
      $display("rgb_to_hsl_fixed test passed");
    end else begin
      $display("rgb_to_hsl_fixed test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("rgb_to_hsl_fixed test failed");
    $finish;
  end

endmodule
